// ===== src/cdq_pkg.sv =====
// Shared types and constants for the circular deque core.
// Used by cdq_ctrl, cdq_dp and circular_deque_core; depends on nothing.
package cdq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic take;      // execute the item on the input ports
    logic load_out;  // move the pending result into the output register
  } dp_cmd_t;

endpackage

// ===== src/cdq_ctrl.sv =====
// Controller of the circular deque core: input/output handshake and sequencing.
// Depends on cdq_pkg for the command struct.
module cdq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cdq_pkg::dp_cmd_t cmd_o
);
  import cdq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   take, load_out;

  assign take     = (state_q == S_IDLE) && in_valid_i;
  assign load_out = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (take) state_d = S_RESP;
      end
      S_RESP: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign cmd_o.take     = take;
  assign cmd_o.load_out = load_out;

  a_take_to_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (state_q == S_RESP))
    else $error("accepted transfer did not move to response state");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q)
    else $error("loaded result not presented");

  a_resp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RESP) && out_valid_q && out_stall_i) |=> (state_q == S_RESP))
    else $error("pending result dropped while output stalled");

endmodule

// ===== src/cdq_dp.sv =====
// Datapath of the circular deque core: ring storage, indices, count and result registers.
// Depends on cdq_pkg for constants, operation and status codes, and the command struct.
module cdq_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cdq_pkg::dp_cmd_t                      cmd_i,
  input  logic [1:0]                            op_i,
  input  logic signed [cdq_pkg::DATA_WIDTH-1:0] data_in_i,
  output logic [1:0]                            status_o,
  output logic signed [cdq_pkg::DATA_WIDTH-1:0] data_out_o,
  output logic [cdq_pkg::CNT_W-1:0]             occupancy_o
);
  import cdq_pkg::*;

  logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;

  logic [IDX_W-1:0] front_q, front_d, rear_q, rear_d, slot;
  logic [CNT_W-1:0] count_q, count_d;
  logic             wr_en, rd_en, is_push, is_front, empty, full;
  status_e          status_d, res_status_q;
  logic             pop_ok_q;

  status_e               st_out_q;
  logic [DATA_WIDTH-1:0] data_out_q;
  logic [CNT_W-1:0]      occ_out_q;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - IDX_W'(1);
  endfunction

  assign is_push  = (op_i == OP_PUSH_FRONT) || (op_i == OP_PUSH_BACK);
  assign is_front = (op_i == OP_PUSH_FRONT) || (op_i == OP_POP_FRONT);
  assign empty    = (count_q == '0);
  assign full     = (count_q == DEPTH_CNT);

  always_comb begin
    front_d  = front_q;
    rear_d   = rear_q;
    count_d  = count_q;
    slot     = '0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    status_d = ST_DONE;
    if (is_push) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        wr_en   = cmd_i.take;
        count_d = count_q + CNT_W'(1);
        if (empty) begin
          front_d = '0;
          rear_d  = '0;
          slot    = '0;
        end else if (is_front) begin
          front_d = ring_prev(front_q);
          slot    = front_d;
        end else begin
          rear_d = ring_next(rear_q);
          slot   = rear_d;
        end
      end
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        rd_en   = cmd_i.take;
        count_d = count_q - CNT_W'(1);
        slot    = is_front ? front_q : rear_q;
        // last entry gone: park both ends at entry zero
        if (count_q == CNT_W'(1)) begin
          front_d = '0;
          rear_d  = '0;
        end else if (is_front) begin
          front_d = ring_next(front_q);
        end else begin
          rear_d = ring_prev(rear_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) ring_mem[slot] <= data_in_i;
    if (rd_en) rd_data_q <= ring_mem[slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.take) begin
      front_q <= front_d;
      rear_q  <= rear_d;
      count_q <= count_d;
    end
  end

  // pending result and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      res_status_q <= status_d;
      pop_ok_q     <= rd_en;
    end
    if (cmd_i.load_out) begin
      st_out_q   <= res_status_q;
      data_out_q <= pop_ok_q ? rd_data_q : '0;
      occ_out_q  <= count_q;
    end
  end

  assign status_o    = st_out_q;
  assign data_out_o  = data_out_q;
  assign occupancy_o = occ_out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("entry count above ring depth");

  a_empty_parked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> ((front_q == '0) && (rear_q == '0)))
    else $error("empty queue with indices away from entry zero");

  a_single_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CNT_W'(1)) |-> (front_q == rear_q))
    else $error("single entry but front and rear differ");

  a_state_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.take |=> ($stable(count_q) && $stable(front_q) && $stable(rear_q)))
    else $error("queue state changed without a transfer");

endmodule

// ===== src/circular_deque_core.sv =====
// Circular deque core: double-ended queue in a ring of DEPTH entries.
// Input channel carries an operation (push front, push back, pop front,
// pop back) and a value; each accepted transfer yields exactly one result
// with a status (done, full, empty), the popped value (zero otherwise)
// and the occupancy after the operation.
// Both channels use valid/stall: a transfer happens on a rising edge with
// valid high and stall low.
// Sequencing: an item is taken in S_IDLE; in S_RESP its result is loaded into
// the output register once that register is free or not stalled, and the input
// stalls until then, so a new item is not taken before the last result is loaded.
// S_RESP comes from the registered read port of the ring storage, needed before a popped value can be presented.
// The next item is taken while a result still waits in the output register;
// if the output stays stalled, the second result waits internally and the
// input stalls until the output register frees up.
// Reset (rst_ni low, asynchronous) empties the queue and clears both
// indices and the output valid; storage contents are not cleared, which is
// harmless because only written entries are ever popped.
// Depends on cdq_pkg, cdq_ctrl and cdq_dp.
module circular_deque_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            op_i,
  input  logic signed [cdq_pkg::DATA_WIDTH-1:0] data_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [1:0]                            status_o,
  output logic signed [cdq_pkg::DATA_WIDTH-1:0] data_out_o,
  output logic [cdq_pkg::CNT_W-1:0]             occupancy_o
);
  import cdq_pkg::*;

  dp_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  cdq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .op_i        (op_i),
    .data_in_i   (data_in_i),
    .status_o    (status_o),
    .data_out_o  (data_out_o),
    .occupancy_o (occupancy_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for circular_deque_core, driven through valid/stall on both sides.
// Depends on cdq_pkg and circular_deque_core; holds its own deque predictor.
module tb_top;
  import cdq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 22;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    status_e               status;
    logic [DATA_WIDTH-1:0] value;
    logic [CNT_W-1:0]      occ;
  } outcome_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [1:0]                   op_i;
  logic signed [DATA_WIDTH-1:0] data_in_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [1:0]                   status_o;
  logic signed [DATA_WIDTH-1:0] data_out_o;
  logic [CNT_W-1:0]             occupancy_o;

  // predictor copy of the deque
  logic [DATA_WIDTH-1:0] mirror_ring [DEPTH];
  logic [IDX_W-1:0]      mirror_front;
  logic [IDX_W-1:0]      mirror_rear;
  logic [CNT_W-1:0]      mirror_count;
  outcome_t              expected_outcomes [$];

  logic steady;
  int   cycle_count;
  int   err_count;
  int   ops_sent;
  int   results_seen;
  int   full_rejects;
  int   empty_rejects;
  int   peak_fill_hits;

  circular_deque_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_out_o  (data_out_o),
    .occupancy_o (occupancy_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_outcomes.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  // receiver stall, random except during steady stretches
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  function automatic void apply_deque_op(op_e op, logic [DATA_WIDTH-1:0] val);
    outcome_t         res;
    logic [IDX_W-1:0] slot;
    res.status = ST_DONE;
    res.value  = '0;
    if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
      if (mirror_count == DEPTH_CNT) begin
        res.status = ST_FULL;
        full_rejects++;
      end else begin
        if (mirror_count == '0) begin
          // empty queue: both ends restart at entry 0
          mirror_front = '0;
          mirror_rear  = '0;
          slot         = '0;
        end else if (op == OP_PUSH_FRONT) begin
          mirror_front = (mirror_front == '0) ? LAST_IDX : mirror_front - IDX_W'(1);
          slot         = mirror_front;
        end else begin
          mirror_rear = (mirror_rear == LAST_IDX) ? '0 : mirror_rear + IDX_W'(1);
          slot        = mirror_rear;
        end
        mirror_ring[slot] = val;
        mirror_count++;
        if (mirror_count == DEPTH_CNT) peak_fill_hits++;
      end
    end else begin
      if (mirror_count == '0) begin
        res.status = ST_EMPTY;
        empty_rejects++;
      end else begin
        slot      = (op == OP_POP_FRONT) ? mirror_front : mirror_rear;
        res.value = mirror_ring[slot];
        mirror_count--;
        if (mirror_count == '0) begin
          mirror_front = '0;
          mirror_rear  = '0;
        end else if (op == OP_POP_FRONT) begin
          mirror_front = (mirror_front == LAST_IDX) ? '0 : mirror_front + IDX_W'(1);
        end else begin
          mirror_rear = (mirror_rear == '0) ? LAST_IDX : mirror_rear - IDX_W'(1);
        end
      end
    end
    res.occ = mirror_count;
    expected_outcomes.push_back(res);
  endfunction

  function automatic void note_error(string what, logic [DATA_WIDTH-1:0] want_v,
                                     logic [DATA_WIDTH-1:0] got_v);
    err_count++;
    if (err_count <= REPORT_MAX)
      $display("mismatch at cycle %0d, %s: expected %h got %h", cycle_count, what,
               want_v, got_v);
  endfunction

  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_outcomes.size() == 0) begin
        note_error("result with nothing pending", '0, data_out_o);
      end else begin
        want = expected_outcomes.pop_front();
        if (status_o !== want.status)
          note_error("status", DATA_WIDTH'(want.status), DATA_WIDTH'(status_o));
        if (data_out_o !== want.value)
          note_error("data_out", want.value, data_out_o);
        if (occupancy_o !== want.occ)
          note_error("occupancy", DATA_WIDTH'(want.occ), DATA_WIDTH'(occupancy_o));
      end
    end
  end

  // one input transfer; valid is left high so the next call can follow back to back
  task automatic send_op(op_e op, logic [DATA_WIDTH-1:0] val);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    data_in_i  <= val;
    do @(posedge clk_i); while (in_stall_o);
    apply_deque_op(op, val);
    ops_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(9))
      0:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      1:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic op_e pick_op(bit push);
    if (push) return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
  endfunction

  task automatic test_directed();
    send_op(OP_POP_FRONT, 32'h1234_5678);
    send_op(OP_POP_BACK, '1);
    // push into an empty queue lands in entry 0 from either end
    send_op(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    send_op(OP_POP_BACK, '0);
    send_op(OP_PUSH_BACK, 32'h8000_0000);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    send_op(OP_PUSH_BACK, 32'h8000_0000);
    send_op(OP_PUSH_FRONT, '1);
    send_op(OP_PUSH_BACK, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '1);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_FRONT, '1);
    send_op(OP_POP_FRONT, '0);
  endtask

  // fill across the wrap point, overflow from both ends, then drain past empty
  task automatic test_fill_and_wrap();
    steady = 1'b1;
    repeat (10) send_op(OP_PUSH_BACK, $urandom);
    repeat (6) send_op(OP_PUSH_FRONT, $urandom);
    send_op(OP_PUSH_FRONT, $urandom);
    send_op(OP_PUSH_BACK, $urandom);
    repeat (8) send_op(OP_POP_FRONT, $urandom);
    repeat (8) send_op(OP_POP_BACK, $urandom);
    send_op(OP_POP_BACK, $urandom);
    send_op(OP_POP_FRONT, $urandom);
    steady = 1'b0;
  endtask

  // hold the sender until every pending result is out, then resume
  task automatic test_drain_pause();
    repeat (3) send_op(pick_op(1'b1), pick_value());
    wait_drained();
    repeat (3) send_op(pick_op(1'b0), pick_value());
  endtask

  task automatic test_random_ops(int n_ops);
    int push_pct;
    int burst;
    int done_ops;
    done_ops = 0;
    while (done_ops < n_ops) begin
      case ($urandom_range(2))
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 15;
      endcase
      burst = $urandom_range(40, 4);
      // a quiet stretch early in the random part
      steady = (done_ops >= 200 && done_ops < 400);
      repeat (burst) begin
        send_op(pick_op($urandom_range(99) < push_pct), pick_value());
        done_ops++;
      end
      if ($urandom_range(7) == 0) wait_drained();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    op_i         <= OP_PUSH_FRONT;
    data_in_i    <= '0;
    out_stall_i  <= 1'b0;
    steady        = 1'b0;
    cycle_count   = 0;
    err_count     = 0;
    ops_sent      = 0;
    results_seen  = 0;
    full_rejects  = 0;
    empty_rejects = 0;
    peak_fill_hits = 0;
    mirror_front  = '0;
    mirror_rear   = '0;
    mirror_count  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_and_wrap();
    test_drain_pause();
    test_random_ops(1600);

    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("summary: %0d operations sent, %0d results checked", ops_sent, results_seen);
    $display("summary: queue filled %0d times, %0d full and %0d empty rejections",
             peak_fill_hits, full_rejects, empty_rejects);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("%0d mismatches in total", err_count);
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/cdq_pkg.sv
src/cdq_ctrl.sv
src/cdq_dp.sv
src/circular_deque_core.sv
tb/sv/tb_top.sv
